### rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion macros used by the complex arithmetic unit RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while in reset
`define CAU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold outside reset
`define CAU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### rtl/cau_pkg.sv
// ============================================================================
// cau_pkg
// Types, codes and helper functions for the complex arithmetic unit.
// ============================================================================
package cau_pkg;

    localparam int DIV_STEPS = 33;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } sat_t;

    typedef struct packed {
        logic [63:0]          rem;
        logic [DIV_STEPS-1:0] quo;
        logic                 neg;
        logic                 ovf;
    } div_lane_t;

    typedef struct packed {
        logic        is_div;
        logic        den_zero;
        logic [63:0] den;
        div_lane_t   re;
        div_lane_t   im;
        logic [31:0] res_re;
        logic [31:0] res_im;
        logic        ovf;
    } pipe_t;

    function automatic sat_t sat65(input logic signed [64:0] x);
        sat_t r;
        logic fits;
        fits  = (x[64:31] == '0) || (x[64:31] == '1);
        r.ovf = ~fits;
        r.val = fits ? x[31:0] : (x[64] ? SAT_MIN : SAT_MAX);
        return r;
    endfunction

endpackage

### rtl/cau_front.sv
// ============================================================================
// cau_front
// Operand products, sums and divider setup over three register stages.
// ============================================================================
module cau_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [1:0]          in_cmd,
    input  logic signed [31:0]  a_re,
    input  logic signed [31:0]  a_im,
    input  logic signed [31:0]  b_re,
    input  logic signed [31:0]  b_im,
    output logic                out_valid,
    output cau_pkg::pipe_t      out_data
);

    localparam int NW = 64 + FRAC_BITS;

    // stage 1
    logic                  v1_reg;
    cau_pkg::cmd_t         cmd1_reg;
    logic signed [63:0]    ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    logic signed [32:0]    sre1_reg, sim1_reg;
    logic                  dz1_reg;
    logic signed [63:0]    ac_next, bd_next, ad_next, bc_next, cc_next, dd_next;
    logic signed [32:0]    sre1_next, sim1_next;

    // stage 2
    logic                  v2_reg;
    cau_pkg::cmd_t         cmd2_reg;
    logic signed [64:0]    rew_reg, imw_reg;
    logic [63:0]           den_reg;
    logic signed [32:0]    sre2_reg, sim2_reg;
    logic                  dz2_reg;
    logic signed [64:0]    rew_next, imw_next;
    logic [63:0]           den_next;

    // stage 3
    logic                  v3_reg;
    cau_pkg::pipe_t        p3_reg;
    cau_pkg::pipe_t        p3_next;

    function automatic cau_pkg::div_lane_t lane_init(input logic signed [64:0] w,
                                                     input logic [63:0] den);
        cau_pkg::div_lane_t l;
        logic [64:0]   mag;
        logic [NW-1:0] num;
        logic [NW-1:0] hi;
        mag   = w[64] ? -w : w;
        num   = NW'(mag[63:0]) << FRAC_BITS;
        hi    = num >> cau_pkg::DIV_STEPS;
        l.neg = w[64];
        l.ovf = (hi >= NW'(den));
        l.rem = hi[63:0];
        l.quo = num[cau_pkg::DIV_STEPS-1:0];
        return l;
    endfunction

    assign ac_next = a_re * b_re;
    assign bd_next = a_im * b_im;
    assign ad_next = a_re * b_im;
    assign bc_next = a_im * b_re;
    assign cc_next = b_re * b_re;
    assign dd_next = b_im * b_im;

    always_comb
    begin
        if (cau_pkg::cmd_t'(in_cmd) == cau_pkg::CMD_SUB)
        begin
            sre1_next = 33'(a_re) - 33'(b_re);
            sim1_next = 33'(a_im) - 33'(b_im);
        end
        else
        begin
            sre1_next = 33'(a_re) + 33'(b_re);
            sim1_next = 33'(a_im) + 33'(b_im);
        end
    end

    always_comb
    begin
        if (cmd1_reg == cau_pkg::CMD_MUL)
        begin
            rew_next = 65'(ac_reg) - 65'(bd_reg);
            imw_next = 65'(ad_reg) + 65'(bc_reg);
        end
        else
        begin
            rew_next = 65'(ac_reg) + 65'(bd_reg);
            imw_next = 65'(bc_reg) - 65'(ad_reg);
        end
        den_next = cc_reg + dd_reg;
    end

    always_comb
    begin
        cau_pkg::sat_t sr, si;
        case (cmd2_reg)
            cau_pkg::CMD_ADD, cau_pkg::CMD_SUB:
            begin
                sr = cau_pkg::sat65(65'(sre2_reg));
                si = cau_pkg::sat65(65'(sim2_reg));
            end
            cau_pkg::CMD_MUL:
            begin
                sr = cau_pkg::sat65(rew_reg >>> FRAC_BITS);
                si = cau_pkg::sat65(imw_reg >>> FRAC_BITS);
            end
            default:
            begin
                sr = '0;
                si = '0;
            end
        endcase
        p3_next.is_div   = (cmd2_reg == cau_pkg::CMD_DIV);
        p3_next.den_zero = dz2_reg;
        p3_next.den      = den_reg;
        p3_next.re       = lane_init(rew_reg, den_reg);
        p3_next.im       = lane_init(imw_reg, den_reg);
        p3_next.res_re   = sr.val;
        p3_next.res_im   = si.val;
        p3_next.ovf      = sr.ovf | si.ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cmd1_reg <= cau_pkg::cmd_t'(in_cmd);
            ac_reg   <= ac_next;
            bd_reg   <= bd_next;
            ad_reg   <= ad_next;
            bc_reg   <= bc_next;
            cc_reg   <= cc_next;
            dd_reg   <= dd_next;
            sre1_reg <= sre1_next;
            sim1_reg <= sim1_next;
            dz1_reg  <= (b_re == '0) && (b_im == '0);
            cmd2_reg <= cmd1_reg;
            rew_reg  <= rew_next;
            imw_reg  <= imw_next;
            den_reg  <= den_next;
            sre2_reg <= sre1_reg;
            sim2_reg <= sim1_reg;
            dz2_reg  <= dz1_reg;
            p3_reg   <= p3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = p3_reg;

endmodule

### rtl/cau_div_step.sv
// ============================================================================
// cau_div_step
// One registered restoring-division step for both result components.
// ============================================================================
module cau_div_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ce,
    input  logic            in_valid,
    input  cau_pkg::pipe_t  in_data,
    output logic            out_valid,
    output cau_pkg::pipe_t  out_data
);

    logic           valid_reg;
    cau_pkg::pipe_t data_reg;
    cau_pkg::pipe_t data_next;

    function automatic cau_pkg::div_lane_t lane_step(input cau_pkg::div_lane_t l,
                                                     input logic [63:0] den);
        cau_pkg::div_lane_t r;
        logic [64:0] t;
        logic [64:0] diff;
        logic        ge;
        t     = {l.rem, l.quo[cau_pkg::DIV_STEPS-1]};
        diff  = t - {1'b0, den};
        ge    = (t >= {1'b0, den});
        r     = l;
        r.rem = ge ? diff[63:0] : t[63:0];
        r.quo = {l.quo[cau_pkg::DIV_STEPS-2:0], ge};
        return r;
    endfunction

    always_comb
    begin
        data_next    = in_data;
        data_next.re = lane_step(in_data.re, in_data.den);
        data_next.im = lane_step(in_data.im, in_data.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ce)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/cau_out_buf.sv
// ============================================================================
// cau_out_buf
// Quotient sign and saturation fix-up, status merge, output register and skid.
// ============================================================================
`include "assert_macros.svh"

module cau_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  cau_pkg::pipe_t  in_data,
    output logic            ce,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [63:0]     m_tdata,    // result_re, result_im
    output logic [1:0]      m_tuser     // status
);

    logic        out_valid_reg, skid_valid_reg;
    logic [65:0] out_reg, skid_reg;
    logic [65:0] res_next;
    logic        push, pop;

    function automatic cau_pkg::sat_t lane_fin(input cau_pkg::div_lane_t l);
        cau_pkg::sat_t r;
        logic big;
        big = l.neg ? (l.quo > 33'h0_8000_0000) : (l.quo > 33'h0_7FFF_FFFF);
        r.ovf = l.ovf | big;
        if (r.ovf)
            r.val = l.neg ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX;
        else
            r.val = l.neg ? (~l.quo[31:0] + 32'd1) : l.quo[31:0];
        return r;
    endfunction

    always_comb
    begin
        cau_pkg::sat_t    fr, fi;
        cau_pkg::status_t st;
        fr = lane_fin(in_data.re);
        fi = lane_fin(in_data.im);
        if (!in_data.is_div)
        begin
            st       = in_data.ovf ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
            res_next = {st, in_data.res_im, in_data.res_re};
        end
        else if (in_data.den_zero)
        begin
            st       = cau_pkg::ST_DIV0;
            res_next = {st, 64'd0};
        end
        else
        begin
            st       = (fr.ovf | fi.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
            res_next = {st, fi.val, fr.val};
        end
    end

    assign ce   = ~skid_valid_reg;
    assign push = ce & in_valid;
    assign pop  = out_valid_reg & m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg | push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
            out_reg <= skid_valid_reg ? skid_reg : res_next;
        else if (push)
            skid_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg[63:0];
    assign m_tuser  = out_reg[65:64];

    `CAU_ASSERT_NEVER(a_skid_needs_out, skid_valid_reg && !out_valid_reg, "skid without output")
    `CAU_ASSERT_IMPL(a_skid_on_stall, $rose(skid_valid_reg),
        $past(out_valid_reg && !m_tready), "skid filled without stall")
    `CAU_ASSERT_IMPL(a_div0_zero, m_tvalid && m_tuser == cau_pkg::ST_DIV0, m_tdata == 64'd0,
        "divide by zero result not zero")
    `CAU_ASSERT_IMPL(a_ovf_sat, m_tvalid && m_tuser == cau_pkg::ST_OVF,
        m_tdata[31:0] == cau_pkg::SAT_MAX || m_tdata[31:0] == cau_pkg::SAT_MIN ||
        m_tdata[63:32] == cau_pkg::SAT_MAX || m_tdata[63:32] == cau_pkg::SAT_MIN,
        "overflow without saturated part")

endmodule

### rtl/complex_arithmetic_unit_core.sv
// ============================================================================
// complex_arithmetic_unit_core
// Pipelined complex add, subtract, multiply and divide in signed fixed point.
// ============================================================================
//  Channel  Dir  tdata                               tuser
//  s_*      in   a_re, a_im, b_re, b_im (128 bits)   command (2 bits)
//  m_*      out  result_re, result_im (64 bits)      status (2 bits)
//
//  Throughput: one transaction per cycle while the output is not stalled.
//  Stages: 3 front stages, 33 quotient-bit stages, 1 output register.
//  Reset clears valid bits only; no clearing pass.
//  A stalled output holds one result and catches one more in a skid register;
//  the pipeline then freezes as a whole and s_tready drops.
// ============================================================================
module complex_arithmetic_unit_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [1:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // result_re, result_im
    output logic [1:0]   m_tuser    // status
);

    logic                               ce;
    logic [cau_pkg::DIV_STEPS:0]        stage_valid;
    cau_pkg::pipe_t                     stage_data [0:cau_pkg::DIV_STEPS];

    assign s_tready = ce;

    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid & ce),
        .in_cmd    (s_tuser),
        .a_re      ($signed(s_tdata[31:0])),
        .a_im      ($signed(s_tdata[63:32])),
        .b_re      ($signed(s_tdata[95:64])),
        .b_im      ($signed(s_tdata[127:96])),
        .out_valid (stage_valid[0]),
        .out_data  (stage_data[0])
    );

    for (genvar i = 0; i < cau_pkg::DIV_STEPS; i++)
    begin : g_div
        cau_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    cau_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid[cau_pkg::DIV_STEPS]),
        .in_data  (stage_data[cau_pkg::DIV_STEPS]),
        .ce       (ce),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit stream test
// Drives add, subtract, multiply and divide transactions on the input stream
// in bursts, stalls the output stream on varying patterns, and compares each
// result with a Q16.16 predictor built on exact 128-bit arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int FRAC = 16;
    localparam int RANDOM_ITEMS = 1030;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        cau_pkg::cmd_t cmd;
        logic [31:0]   a_re;
        logic [31:0]   a_im;
        logic [31:0]   b_re;
        logic [31:0]   b_im;
    } cplx_op_t;

    typedef struct {
        logic [31:0]      re;
        logic [31:0]      im;
        cau_pkg::status_t status;
    } cplx_res_t;

    typedef struct {
        cplx_op_t  op;
        bit        typed;
        cplx_res_t res;
    } vector_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // a_re, a_im, b_re, b_im
    logic [1:0]   s_tuser;   // command
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // result_re, result_im
    logic [1:0]   m_tuser;   // status

    cplx_res_t pending_results[$];
    vector_t   vectors[$];
    int        mismatches = 0;
    int        received = 0;
    int        cycles = 0;
    int        cmd_seen[4];
    int        status_seen[4];
    bit        stim_done = 0;

    complex_arithmetic_unit_core #(.FRAC_BITS(FRAC)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] clamp32(input logic signed [127:0] x, inout bit ovf);
        if (x > 128'sd2147483647)
        begin
            ovf = 1;
            return cau_pkg::SAT_MAX;
        end
        if (x < -128'sd2147483648)
        begin
            ovf = 1;
            return cau_pkg::SAT_MIN;
        end
        return x[31:0];
    endfunction

    function automatic logic [31:0] quotient(input logic signed [127:0] num,
                                             input logic [127:0] den, inout bit ovf);
        logic [127:0]        mag;
        logic [127:0]        quo;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        quo = (mag << FRAC) / den;
        q = (num < 0) ? -$signed(quo) : $signed(quo);
        return clamp32(q, ovf);
    endfunction

    function automatic cplx_res_t predict_complex(input cplx_op_t op);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        logic signed [127:0] d;
        logic [127:0]        den;
        bit                  ovf;
        cplx_res_t           r;
        a = $signed(op.a_re);
        b = $signed(op.a_im);
        c = $signed(op.b_re);
        d = $signed(op.b_im);
        ovf = 0;
        r.re = '0;
        r.im = '0;
        r.status = cau_pkg::ST_OK;
        case (op.cmd)
            cau_pkg::CMD_ADD:
            begin
                r.re = clamp32(a + c, ovf);
                r.im = clamp32(b + d, ovf);
            end
            cau_pkg::CMD_SUB:
            begin
                r.re = clamp32(a - c, ovf);
                r.im = clamp32(b - d, ovf);
            end
            cau_pkg::CMD_MUL:
            begin
                r.re = clamp32((a * c - b * d) >>> FRAC, ovf);
                r.im = clamp32((a * d + b * c) >>> FRAC, ovf);
            end
            default:
            begin
                den = c * c + d * d;
                if (den == 0)
                    r.status = cau_pkg::ST_DIV0;
                else
                begin
                    r.re = quotient(a * c + b * d, den, ovf);
                    r.im = quotient(b * c - a * d, den, ovf);
                end
            end
        endcase
        if (r.status == cau_pkg::ST_OK && ovf)
            r.status = cau_pkg::ST_OVF;
        return r;
    endfunction

    task automatic add_vector(input cau_pkg::cmd_t cmd, input logic [31:0] ar,
                              input logic [31:0] ai,
                              input logic [31:0] br, input logic [31:0] bi, input bit typed,
                              input logic [31:0] re, input logic [31:0] im,
                              input cau_pkg::status_t st);
        vector_t v;
        v.op = '{cmd, ar, ai, br, bi};
        v.typed = typed;
        v.res = '{re, im, st};
        vectors.push_back(v);
    endtask

    task automatic send_op(input cplx_op_t op, input cplx_res_t res);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {op.b_im, op.b_re, op.a_im, op.a_re};
        s_tuser <= op.cmd;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(res);
        cmd_seen[op.cmd]++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return cau_pkg::SAT_MAX;
            1: return cau_pkg::SAT_MIN;
            2: return '0;
            3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            5: return 32'h0001_0000 << $urandom_range(0, 14);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        cplx_res_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            received++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result re=%h im=%h status=%0d",
                             m_tdata[31:0], m_tdata[63:32], m_tuser);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                status_seen[exp_res.status]++;
                if (m_tdata[31:0] !== exp_res.re || m_tdata[63:32] !== exp_res.im ||
                    m_tuser !== exp_res.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp re=%h im=%h st=%0d got re=%h im=%h st=%0d",
                                 received, exp_res.re, exp_res.im, exp_res.status,
                                 m_tdata[31:0], m_tdata[63:32], m_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int left;
        m_tready = 1'b0;
        @(negedge clk);
        while (!stim_done || pending_results.size() != 0)
        begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 200);
            while (left > 0)
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) < 7);
                    2: m_tready <= ($urandom_range(0, 9) < 2);
                    default: m_tready <= ((cycles % 8) < 3);
                endcase
                @(negedge clk);
                left--;
            end
        end
        m_tready <= 1'b1;
    end

    initial
    begin
        cplx_op_t  op;
        cplx_res_t res;
        int        burst;
        bit        drained;
        drained = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = cau_pkg::CMD_ADD;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_vector(cau_pkg::CMD_ADD, 0, 0, 0, 0, 1, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_ADD, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN, cau_pkg::SAT_MAX,
                   cau_pkg::SAT_MIN, 1, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN, cau_pkg::ST_OVF);
        add_vector(cau_pkg::CMD_ADD, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN, cau_pkg::SAT_MIN,
                   cau_pkg::SAT_MAX, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_SUB, cau_pkg::SAT_MIN, cau_pkg::SAT_MAX, 1, 32'hFFFF_FFFF, 1,
                   cau_pkg::SAT_MIN, cau_pkg::SAT_MAX, cau_pkg::ST_OVF);
        add_vector(cau_pkg::CMD_SUB, 5, 7, 5, 7, 1, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_MUL, 0, 0, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN, 1, 0, 0,
                   cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_MUL, cau_pkg::SAT_MAX, 0, cau_pkg::SAT_MAX, 0, 1,
                   cau_pkg::SAT_MAX, 0, cau_pkg::ST_OVF);
        add_vector(cau_pkg::CMD_MUL, 32'h0001_0000, 0, 32'h1234_5678, 32'h8765_4321, 1,
                   32'h1234_5678, 32'h8765_4321, cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_MUL, cau_pkg::SAT_MIN, cau_pkg::SAT_MIN, cau_pkg::SAT_MIN,
                   cau_pkg::SAT_MIN, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_MUL, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_MUL, 32'h0003_8000, 32'hFFFE_4000, 32'h0000_C000,
                   32'h0002_0000, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_DIV, 32'h1234_5678, 32'h8765_4321, 0, 0, 1, 0, 0,
                   cau_pkg::ST_DIV0);
        add_vector(cau_pkg::CMD_DIV, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN, 0, 0, 1, 0, 0,
                   cau_pkg::ST_DIV0);
        add_vector(cau_pkg::CMD_DIV, 5, 7, 32'h0001_0000, 0, 1, 5, 7, cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_DIV, cau_pkg::SAT_MAX, 0, 1, 0, 1, cau_pkg::SAT_MAX, 0,
                   cau_pkg::ST_OVF);
        add_vector(cau_pkg::CMD_DIV, cau_pkg::SAT_MIN, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN,
                   cau_pkg::SAT_MIN, 0, 0, 0, cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_DIV, 32'hFFFF_FFFF, 0, 32'h0003_0000, 0, 0, 0, 0,
                   cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_DIV, 0, 32'h0002_0000, 0, 32'h0001_0000, 0, 0, 0,
                   cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_DIV, 32'h0001_0000, 32'h0001_0000, 1, 32'hFFFF_FFFF, 0, 0, 0,
                   cau_pkg::ST_OK);
        add_vector(cau_pkg::CMD_DIV, cau_pkg::SAT_MAX, cau_pkg::SAT_MAX, cau_pkg::SAT_MAX,
                   cau_pkg::SAT_MAX, 0, 0, 0, cau_pkg::ST_OK);

        foreach (vectors[i])
        begin
            res = vectors[i].typed ? vectors[i].res : predict_complex(vectors[i].op);
            send_op(vectors[i].op, res);
            if ($urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 4));
        end

        for (int n = 0; n < RANDOM_ITEMS; )
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++)
            begin
                op.cmd = cau_pkg::cmd_t'($urandom_range(0, 3));
                op.a_re = rand_operand();
                op.a_im = rand_operand();
                op.b_re = rand_operand();
                op.b_im = rand_operand();
                if (op.cmd == cau_pkg::CMD_DIV && $urandom_range(0, 15) == 0)
                begin
                    op.b_re = '0;
                    op.b_im = '0;
                end
                send_op(op, predict_complex(op));
            end
            if (!drained && n >= RANDOM_ITEMS / 2)
            begin
                drained = 1;
                idle_gap(1);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            else
                idle_gap($urandom_range(0, 12));
        end
        idle_gap(1);
        stim_done = 1;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("commands add/sub/mul/div: %0d/%0d/%0d/%0d, results checked: %0d",
                 cmd_seen[cau_pkg::CMD_ADD], cmd_seen[cau_pkg::CMD_SUB],
                 cmd_seen[cau_pkg::CMD_MUL], cmd_seen[cau_pkg::CMD_DIV], received);
        $display("status ok/overflow/div-by-zero: %0d/%0d/%0d, mismatches: %0d",
                 status_seen[cau_pkg::ST_OK], status_seen[cau_pkg::ST_OVF],
                 status_seen[cau_pkg::ST_DIV0], mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/cau_out_buf.sv
rtl/complex_arithmetic_unit_core.sv
tb/testbench.sv
